@@ rtl/hkt_pkg.sv @@
// Shared types and constants for the hashed key table.
// No dependencies.
`timescale 1ns / 1ps
package hkt_pkg;

  localparam int unsigned BUCKETS   = 256;
  localparam int unsigned WAYS      = 4;
  localparam int unsigned KEY_LIMIT = 46;
  localparam int unsigned KEY_MAX   = KEY_LIMIT - 1;
  localparam int unsigned SLOTS     = BUCKETS * WAYS;

  localparam int unsigned BUCKET_W  = $clog2(BUCKETS);
  localparam int unsigned WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned LEN_W     = $clog2(KEY_LIMIT);
  localparam int unsigned KADDR_W   = $clog2(BUCKETS * KEY_MAX);
  localparam int unsigned COUNT_W   = 11;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_FULL      = 3'd3,
    ST_HIT       = 3'd4,
    ST_MISS      = 3'd5
  } status_e;

  typedef struct packed {
    logic       action;
    logic [7:0] key_char;
    logic       last_char;
    logic [7:0] list_id;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [7:0]           found_list;
    logic [COUNT_W-1:0]   entry_count;
  } out_item_t;

  // Snapshot of a finished key, taken on its last character
  typedef struct packed {
    logic [BUCKET_W-1:0] bucket;
    logic [LEN_W-1:0]    len;
    logic                over;
  } key_info_t;

  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic [7:0]       list;
  } slot_meta_t;

  // One bucket row: valid bits plus per-way length and list
  typedef struct packed {
    logic [WAYS-1:0]              valid;
    slot_meta_t [WAYS-1:0]        meta;
  } row_t;

  // Key byte address: bucket row of KEY_MAX words, one byte lane per way
  function automatic logic [KADDR_W-1:0] key_addr(logic [BUCKET_W-1:0] bucket,
                                                  logic [LEN_W-1:0] idx);
    key_addr = KADDR_W'(KADDR_W'(bucket) * KADDR_W'(KEY_MAX)) + KADDR_W'(idx);
  endfunction

endpackage

@@ rtl/hkt_hash.sv @@
// FNV-1a accumulator, key length tracking and the incoming key buffer memory.
// Depends on hkt_pkg.
`timescale 1ns / 1ps
module hkt_hash import hkt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             char_we_i,
  input  logic [7:0]       key_char_i,
  input  logic             last_char_i,
  input  logic [LEN_W-1:0] kb_raddr_i,
  output logic [7:0]       kb_rdata_o,
  output key_info_t        info_o
);

  logic [31:0]      hash_q, hash_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic             over_q, over_d;
  logic             room;
  key_info_t        info_q;
  logic [7:0]       kb_mem [KEY_MAX];
  logic [7:0]       kb_rdata_q;

  // Fold one character and advance the length
  always_comb begin
    room   = (len_q < LEN_W'(KEY_MAX));
    hash_d = 32'((hash_q ^ {24'd0, key_char_i}) * FNV_PRIME);
    len_d  = room ? len_q + LEN_W'(1) : len_q;
    over_d = over_q | ~room;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
      len_q  <= '0;
      over_q <= 1'b0;
    end else if (char_we_i) begin
      if (last_char_i) begin
        hash_q <= FNV_BASIS;
        len_q  <= '0;
        over_q <= 1'b0;
      end else begin
        hash_q <= hash_d;
        len_q  <= len_d;
        over_q <= over_d;
      end
    end
  end

  // Key snapshot for the lookup pass
  always_ff @(posedge clk_i) begin
    if (char_we_i && last_char_i) begin
      info_q.bucket <= BUCKET_W'(hash_d % BUCKETS);
      info_q.len    <= len_d;
      info_q.over   <= over_d;
    end
  end

  // Key buffer memory
  always_ff @(posedge clk_i) begin
    if (char_we_i && room) begin
      kb_mem[len_q] <= key_char_i;
    end
    kb_rdata_q <= kb_mem[kb_raddr_i];
  end

  assign kb_rdata_o = kb_rdata_q;
  assign info_o     = info_q;

endmodule

@@ rtl/hkt_store.sv @@
// Table storage: bucket row memory (valid, length, list) and key byte memory.
// Depends on hkt_pkg.
`timescale 1ns / 1ps
module hkt_store import hkt_pkg::*; (
  input  logic                 clk_i,
  input  logic [BUCKET_W-1:0]  row_raddr_i,
  output row_t                 row_rdata_o,
  input  logic                 row_we_i,
  input  logic [BUCKET_W-1:0]  row_waddr_i,
  input  row_t                 row_wdata_i,
  input  logic [KADDR_W-1:0]   key_raddr_i,
  output logic [WAYS*8-1:0]    key_rdata_o,
  input  logic                 key_we_i,
  input  logic [KADDR_W-1:0]   key_waddr_i,
  input  logic [WAY_W-1:0]     key_wlane_i,
  input  logic [7:0]           key_wdata_i
);

  row_t              row_mem [BUCKETS];
  row_t              row_rdata_q;
  logic [WAYS*8-1:0] key_mem [BUCKETS*KEY_MAX];
  logic [WAYS*8-1:0] key_rdata_q;

  // Row memory
  always_ff @(posedge clk_i) begin
    if (row_we_i) begin
      row_mem[row_waddr_i] <= row_wdata_i;
    end
    row_rdata_q <= row_mem[row_raddr_i];
  end

  // Key byte memory with a byte write enable per way
  always_ff @(posedge clk_i) begin
    for (int w = 0; w < WAYS; w++) begin
      if (key_we_i && (key_wlane_i == WAY_W'(w))) begin
        key_mem[key_waddr_i][w*8 +: 8] <= key_wdata_i;
      end
    end
    key_rdata_q <= key_mem[key_raddr_i];
  end

  assign row_rdata_o = row_rdata_q;
  assign key_rdata_o = key_rdata_q;

endmodule

@@ rtl/hashed_key_table_insert_lookup.sv @@
// Hashed key table: insert and lookup of text keys, one character per item.
// Non-final characters are taken one per cycle. After a final character the
// block is busy: it reads the bucket row (S_ROW, S_FETCH), compares the key
// (L = buffered key length, at most 45) one byte per cycle across all ways of
// the bucket (S_CMP) and registers the result as it leaves S_DONE. After reset
// a clearing pass sweeps all 256 bucket rows before the first item is accepted.
`timescale 1ns / 1ps
module hashed_key_table_insert_lookup import hkt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ROW   = 6'b000100,
    S_FETCH = 6'b001000,
    S_CMP   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  logic [BUCKET_W-1:0] clr_q, clr_d;
  logic [LEN_W-1:0]    idx_q, idx_d;
  logic                action_q;
  logic [7:0]          list_q;
  row_t                row_q;
  logic [WAYS-1:0]     eq_q, eq_d;
  logic [WAY_W-1:0]    free_q, free_d;
  logic                have_free_q, have_free_d;
  logic [COUNT_W-1:0]  total_q, total_d;
  logic                out_valid_q;
  out_item_t           out_q, out_d;

  logic                in_acc;
  logic                finish;
  key_info_t           info;
  logic [7:0]          kb_rdata;
  row_t                row_rdata;
  logic [WAYS*8-1:0]   key_rdata;
  logic [LEN_W-1:0]    rd_idx;
  logic                row_we;
  logic [BUCKET_W-1:0] row_waddr;
  row_t                row_wdata;
  logic                key_we;
  logic [WAY_W-1:0]    hit_way;
  logic                any_eq;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  hkt_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .char_we_i  (in_acc),
    .key_char_i (in_item_i.key_char),
    .last_char_i(in_item_i.last_char),
    .kb_raddr_i (rd_idx),
    .kb_rdata_o (kb_rdata),
    .info_o     (info)
  );

  // Byte read index, held inside the buffered key
  assign rd_idx = (idx_q < info.len) ? idx_q : '0;

  hkt_store u_store (
    .clk_i       (clk_i),
    .row_raddr_i (info.bucket),
    .row_rdata_o (row_rdata),
    .row_we_i    (row_we),
    .row_waddr_i (row_waddr),
    .row_wdata_i (row_wdata),
    .key_raddr_i (key_addr(info.bucket, rd_idx)),
    .key_rdata_o (key_rdata),
    .key_we_i    (key_we),
    .key_waddr_i (key_addr(info.bucket, idx_q - LEN_W'(1))),
    .key_wlane_i (free_q),
    .key_wdata_i (kb_rdata)
  );

  // Speculative copy into the free way while comparing; harmless if unused
  assign key_we = (state_q == S_CMP) && (action_q == ACT_INSERT) &&
                  have_free_q && !info.over;

  // Lowest matching way
  always_comb begin
    hit_way = '0;
    any_eq  = 1'b0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (eq_q[w]) begin
        hit_way = WAY_W'(w);
        any_eq  = 1'b1;
      end
    end
  end

  assign finish = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Sequencer, compare and result
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    eq_d        = eq_q;
    free_d      = free_q;
    have_free_d = have_free_q;
    total_d     = total_q;
    out_d       = out_q;
    row_we      = 1'b0;
    row_waddr   = info.bucket;
    row_wdata   = row_q;

    case (state_q)
      S_CLEAR: begin
        row_we    = 1'b1;
        row_waddr = clr_q;
        row_wdata = '0;
        clr_d     = clr_q + BUCKET_W'(1);
        if (clr_q == BUCKET_W'(BUCKETS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        idx_d = '0;
        if (in_acc && in_item_i.last_char) begin
          state_d = S_ROW;
        end
      end
      S_ROW: begin
        state_d = S_FETCH;
      end
      S_FETCH: begin
        have_free_d = 1'b0;
        free_d      = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
          eq_d[w] = row_rdata.valid[w] && (row_rdata.meta[w].len == info.len);
          if (!row_rdata.valid[w]) begin
            have_free_d = 1'b1;
            free_d      = WAY_W'(w);
          end
        end
        idx_d   = idx_q + LEN_W'(1);
        state_d = S_CMP;
      end
      S_CMP: begin
        for (int w = 0; w < WAYS; w++) begin
          eq_d[w] = eq_q[w] && (key_rdata[w*8 +: 8] == kb_rdata);
        end
        if (idx_q == info.len) begin
          state_d = S_DONE;
        end else begin
          idx_d = idx_q + LEN_W'(1);
        end
      end
      S_DONE: begin
        if (finish) begin
          out_d.found_list = '0;
          if (action_q == ACT_INSERT) begin
            if (info.over) begin
              out_d.status = ST_TOO_LONG;
            end else if (any_eq) begin
              out_d.status = ST_DUPLICATE;
            end else if (have_free_q) begin
              out_d.status                = ST_INSERTED;
              row_we                      = 1'b1;
              row_wdata.valid[free_q]     = 1'b1;
              row_wdata.meta[free_q].len  = info.len;
              row_wdata.meta[free_q].list = list_q;
              total_d                     = total_q + COUNT_W'(1);
            end else begin
              out_d.status = ST_FULL;
            end
          end else if (!info.over && any_eq) begin
            out_d.status     = ST_HIT;
            out_d.found_list = row_q.meta[hit_way].list;
          end else begin
            out_d.status = ST_MISS;
          end
          out_d.entry_count = total_d;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      total_q <= total_d;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    eq_q        <= eq_d;
    free_q      <= free_d;
    have_free_q <= have_free_d;
    out_q       <= out_d;
    if (in_acc && in_item_i.last_char) begin
      action_q <= in_item_i.action;
      list_q   <= in_item_i.list_id;
    end
    if (state_q == S_FETCH) begin
      row_q <= row_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
